### sv/h264nal_pkg.sv
// Package for the H.264 Annex B NAL splitter: constants, NAL type codes, result type.
package h264nal_pkg;

  localparam int POSITION_BITS = 32;
  // compare width for lengths against the 32-bit zero-run count
  localparam int LEN_W = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  localparam logic [7:0] TYPE_MASK    = 8'h1f;
  localparam logic [7:0] FIRST_MB_BIT = 8'h80;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam logic [4:0] NAL_SLICE      = 5'd1;
  localparam logic [4:0] NAL_IDR        = 5'd5;
  localparam logic [4:0] NAL_SEI        = 5'd6;
  localparam logic [4:0] NAL_SPS        = 5'd7;
  localparam logic [4:0] NAL_AUD        = 5'd9;
  localparam logic [4:0] NAL_END_STREAM = 5'd11;
  localparam logic [4:0] NAL_FILLER     = 5'd12;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LEN_W-1:0]         len_t;

  typedef struct packed {
    logic [4:0]  nal_type;
    logic [31:0] nal_offset;
    logic [31:0] nal_length;
    logic        new_access_unit;
    logic        has_picture;
    logic        last_of_run;
  } result_t;

endpackage

### sv/h264_nal_access_unit_splitter_top.sv
// H.264 Annex B start-code parser: splits a byte stream into NAL units, flags access units.
// A NAL result is written into the output buffer at the end of the byte beat that closes it.
// Throughput: one stream byte per cycle while in_ready is high; a byte that closes two NALs
// puts two results into the 4-entry output buffer, which drains one result per cycle while out_ready is high.
// Input is taken while at least two output buffer entries are free after this cycle's pop.
// Reset (rst, synchronous) clears the parse state and empties the output buffer.
module h264_nal_access_unit_splitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  nal_type,
  output logic [31:0] nal_offset,
  output logic [31:0] nal_length,
  output logic        new_access_unit,
  output logic        has_picture,
  output logic        last_of_run
);
  import h264nal_pkg::*;

  function automatic result_t close_nal(input pos_t end_pos, input pos_t start_pos,
                                        input len_t trailing, input logic [4:0] typ,
                                        input logic fmb, input logic prev);
    pos_t       raw;
    len_t       raw_w;
    logic [4:0] t;
    logic       f;
    logic       pic;
    result_t    r;
    raw   = end_pos - start_pos;
    raw_w = LEN_W'(raw);
    // short NALs: no header byte means type 0, no second byte means bit 0
    t     = (raw_w >= LEN_W'(4)) ? typ : 5'd0;
    f     = (raw_w >= LEN_W'(5)) ? fmb : 1'b0;
    pic   = (t == NAL_SLICE) || (t == NAL_IDR);
    r.nal_type    = t;
    r.nal_offset  = 32'(start_pos);
    r.nal_length  = (trailing > raw_w) ? 32'd0 : 32'(raw_w - trailing);
    r.has_picture = pic;
    if (pic) begin
      r.new_access_unit = prev && f;
    end else begin
      r.new_access_unit = prev && ((t == NAL_SEI) || (t == NAL_SPS) || (t == NAL_AUD) ||
                                   (t == NAL_END_STREAM) || (t == NAL_FILLER));
    end
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // parse state
  pos_t        position;
  logic [31:0] zero_run;
  logic        nal_open;
  pos_t        open_start;
  logic [1:0]  header_count;
  logic [4:0]  open_type;
  logic        open_first_mb;
  logic        prev_picture;

  pos_t        position_next;
  logic [31:0] zero_run_next;
  logic        nal_open_next;
  pos_t        open_start_next;
  logic [1:0]  header_count_next;
  logic [4:0]  open_type_next;
  logic        open_first_mb_next;
  logic        prev_mid;

  logic        start_code;
  pos_t        sc_start;
  logic        close1;
  logic        close2;
  result_t     res1;
  result_t     res2;

  // output buffer
  result_t            out_buf [OUT_DEPTH];
  logic [OUT_AW-1:0]  wr_ptr;
  logic [OUT_AW-1:0]  rd_ptr;
  logic [OUT_AW:0]    count;
  logic [OUT_AW:0]    count_after_pop;
  logic               in_fire;
  logic               out_fire;
  logic [1:0]         push_n;
  result_t            head;

  always_comb begin
    start_code = (stream_byte == 8'h01) && (zero_run >= 32'd2);
    sc_start   = position - pos_t'(2);
    close1     = start_code && nal_open;
    res1       = close_nal(sc_start, open_start, LEN_W'(zero_run - 32'd2),
                           open_type, open_first_mb, prev_picture);
    prev_mid   = close1 ? res1.has_picture : prev_picture;

    nal_open_next      = nal_open;
    open_start_next    = open_start;
    header_count_next  = header_count;
    open_type_next     = open_type;
    open_first_mb_next = open_first_mb;
    if (start_code) begin
      nal_open_next      = 1'b1;
      open_start_next    = sc_start;
      header_count_next  = 2'd0;
      open_type_next     = 5'd0;
      open_first_mb_next = 1'b0;
    end else if (nal_open && (header_count < 2'd2)) begin
      if (header_count == 2'd0) begin
        open_type_next = 5'(stream_byte & TYPE_MASK);
      end else begin
        open_first_mb_next = (stream_byte & FIRST_MB_BIT) != 8'd0;
      end
      header_count_next = header_count + 2'd1;
    end

    if (stream_byte == 8'd0) begin
      zero_run_next = (zero_run == 32'hffff_ffff) ? zero_run : zero_run + 32'd1;
    end else begin
      zero_run_next = 32'd0;
    end
    position_next = position + pos_t'(1);

    // end of stream closes whatever is open after this byte; the byte counts unless it is a trailing zero
    close2 = end_of_stream && nal_open_next;
    res2   = close_nal(position_next, open_start_next, LEN_W'(zero_run_next),
                       open_type_next, open_first_mb_next, prev_mid);
    res1.last_of_run = !close2;
    res2.last_of_run = 1'b1;
  end

  assign count_after_pop = count - {{OUT_AW{1'b0}}, out_fire};
  assign in_ready        = count_after_pop <= (OUT_AW + 1)'(OUT_DEPTH - 2);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = count != '0;
  assign out_fire        = out_valid && out_ready;
  assign push_n          = in_fire ? ({1'b0, close1} + {1'b0, close2}) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      zero_run      <= '0;
      nal_open      <= 1'b0;
      open_start    <= '0;
      header_count  <= '0;
      open_type     <= '0;
      open_first_mb <= 1'b0;
      prev_picture  <= 1'b0;
    end else if (in_fire) begin
      if (end_of_stream) begin
        position      <= '0;
        zero_run      <= '0;
        nal_open      <= 1'b0;
        open_start    <= '0;
        header_count  <= '0;
        open_type     <= '0;
        open_first_mb <= 1'b0;
        prev_picture  <= 1'b0;
      end else begin
        position      <= position_next;
        zero_run      <= zero_run_next;
        nal_open      <= nal_open_next;
        open_start    <= open_start_next;
        header_count  <= header_count_next;
        open_type     <= open_type_next;
        open_first_mb <= open_first_mb_next;
        prev_picture  <= prev_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_AW'(push_n);
      rd_ptr <= rd_ptr + OUT_AW'(out_fire);
      count  <= count_after_pop + (OUT_AW + 1)'(push_n);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && close1) begin
      out_buf[wr_ptr] <= res1;
    end
    if (in_fire && close2) begin
      out_buf[close1 ? wr_ptr + OUT_AW'(1) : wr_ptr] <= res2;
    end
  end

  assign head            = out_buf[rd_ptr];
  assign nal_type        = head.nal_type;
  assign nal_offset      = head.nal_offset;
  assign nal_length      = head.nal_length;
  assign new_access_unit = head.new_access_unit;
  assign has_picture     = head.has_picture;
  assign last_of_run     = head.last_of_run;

endmodule

### tb/h264_nal_splitter_checker.sv
`timescale 1ns / 100ps
// Checker for the NAL splitter: mirrors the byte parser and compares every result beat.
module h264_nal_splitter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_stream,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [4:0]  nal_type,
  input  logic [31:0] nal_offset,
  input  logic [31:0] nal_length,
  input  logic        new_access_unit,
  input  logic        has_picture,
  input  logic        last_of_run,
  output int          failures,
  output int          pending
);
  import h264nal_pkg::*;

  // parser mirror
  pos_t        stream_pos;
  pos_t        unit_start;
  logic [31:0] zero_count;
  logic        unit_open;
  logic [2:0]  header_seen;
  logic [4:0]  unit_type;
  logic        unit_first_mb;
  logic        prev_was_picture;

  result_t nal_results_due[$];

  task automatic clear_parser();
    stream_pos       = '0;
    unit_start       = '0;
    zero_count       = '0;
    unit_open        = 1'b0;
    header_seen      = '0;
    unit_type        = '0;
    unit_first_mb    = 1'b0;
    prev_was_picture = 1'b0;
  endtask

  task automatic close_unit(input pos_t stop, input logic [63:0] trailing,
                            output result_t r);
    pos_t       span;
    logic [4:0] t;
    logic       fmb;
    logic       pic;
    logic       nau;
    span = stop - unit_start;
    // header bytes only count if the unit is long enough to hold them
    t   = (span >= 4) ? unit_type : 5'd0;
    fmb = (span >= 5) ? unit_first_mb : 1'b0;
    pic = (t == NAL_SLICE) || (t == NAL_IDR);
    if (pic)
      nau = prev_was_picture && fmb;
    else
      nau = prev_was_picture && (t == NAL_SEI || t == NAL_SPS || t == NAL_AUD ||
                                 t == NAL_END_STREAM || t == NAL_FILLER);
    prev_was_picture  = pic;
    r.nal_type        = t;
    r.nal_offset      = 32'(unit_start);
    r.nal_length      = (trailing > 64'(span)) ? 32'd0 : 32'(64'(span) - trailing);
    r.new_access_unit = nau;
    r.has_picture     = pic;
    r.last_of_run     = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eos);
    result_t closed [2];
    int      produced;
    pos_t    here;
    produced = 0;
    here     = stream_pos;
    if (b == 8'h01 && zero_count >= 2) begin
      if (unit_open) begin
        close_unit(here - 2, 64'(zero_count) - 2, closed[produced]);
        produced++;
      end
      unit_open     = 1'b1;
      unit_start    = here - 2;
      header_seen   = '0;
      unit_type     = '0;
      unit_first_mb = 1'b0;
    end else if (unit_open && header_seen < 2) begin
      if (header_seen == 0)
        unit_type = 5'(b & TYPE_MASK);
      else
        unit_first_mb = |(b & FIRST_MB_BIT);
      header_seen++;
    end
    if (b == 8'h00) begin
      if (zero_count != '1)
        zero_count++;
    end else begin
      zero_count = '0;
    end
    stream_pos = here + 1;
    if (eos) begin
      if (unit_open) begin
        close_unit(stream_pos, 64'(zero_count), closed[produced]);
        produced++;
      end
      clear_parser();
    end
    if (produced > 0)
      closed[produced-1].last_of_run = 1'b1;
    for (int i = 0; i < produced; i++)
      nal_results_due.push_back(closed[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (nal_results_due.size() == 0) begin
      $error("unexpected NAL result: type %0d offset %0d length %0d",
             nal_type, nal_offset, nal_length);
      failures++;
    end else begin
      want = nal_results_due.pop_front();
      compare_field("nal_type", 32'(want.nal_type), 32'(nal_type));
      compare_field("nal_offset", want.nal_offset, nal_offset);
      compare_field("nal_length", want.nal_length, nal_length);
      compare_field("new_access_unit", 32'(want.new_access_unit), 32'(new_access_unit));
      compare_field("has_picture", 32'(want.has_picture), 32'(has_picture));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      nal_results_due.delete();
    end else begin
      // a result reaches the output only after its byte is registered, so order here does not matter
      if (out_valid && out_ready)
        check_result();
      if (in_valid && in_ready)
        parse_byte(stream_byte, end_of_stream);
    end
    pending <= nal_results_due.size();
  end

endmodule

### tb/h264_nal_access_unit_splitter_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the NAL splitter: clock, reset, byte stream stimulus and verdict.
module h264_nal_access_unit_splitter_top_tb;
  import h264nal_pkg::*;

  localparam int PHASE_BYTES = 520;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = 8'h00;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  nal_type;
  logic [31:0] nal_offset;
  logic [31:0] nal_length;
  logic        new_access_unit;
  logic        has_picture;
  logic        last_of_run;

  int failures;
  int pending;
  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;

  h264_nal_access_unit_splitter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .stream_byte(stream_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .nal_type(nal_type), .nal_offset(nal_offset), .nal_length(nal_length),
    .new_access_unit(new_access_unit), .has_picture(has_picture),
    .last_of_run(last_of_run)
  );

  h264_nal_splitter_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .stream_byte(stream_byte), .end_of_stream(end_of_stream),
    .out_valid(out_valid), .out_ready(out_ready),
    .nal_type(nal_type), .nal_offset(nal_offset), .nal_length(nal_length),
    .new_access_unit(new_access_unit), .has_picture(has_picture),
    .last_of_run(last_of_run),
    .failures(failures), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_beat(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    stream_byte   <= b;
    end_of_stream <= eos;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  function automatic logic [4:0] pick_nal_type();
    case ($urandom_range(9))
      0, 1:    return NAL_SLICE;
      2:       return NAL_IDR;
      3:       return NAL_SEI;
      4:       return NAL_SPS;
      5:       return NAL_AUD;
      6:       return NAL_END_STREAM;
      7:       return NAL_FILLER;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  // one NAL with random content, or now and then noise or a broken start code
  task automatic emit_unit();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 6)) send_beat(8'($urandom), $urandom_range(99) < 4);
    end else if (roll < 14) begin
      send_beat(8'h00, 1'b0);
      if ($urandom_range(1) == 1)
        send_beat(8'h00, 1'b0);
      send_beat(8'($urandom_range(2, 255)), 1'b0);
    end else begin
      repeat (($urandom_range(3) == 0) ? $urandom_range(3, 4) : 2) send_beat(8'h00, 1'b0);
      if ($urandom_range(49) == 0) begin
        send_beat(8'h01, 1'b1);
        return;
      end
      send_beat(8'h01, 1'b0);
      roll = $urandom_range(19);
      if (roll == 0)
        return;
      send_beat({3'($urandom), pick_nal_type()}, 1'b0);
      if (roll == 1)
        return;
      send_beat(8'($urandom), 1'b0);
      repeat ($urandom_range(10))
        send_beat(($urandom_range(3) == 0) ? 8'h00 : 8'($urandom), 1'b0);
      if ($urandom_range(2) == 0)
        repeat ($urandom_range(1, 3)) send_beat(8'h00, 1'b0);
      if ($urandom_range(24) == 0)
        send_beat(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // end of stream with nothing open
    send_beat(8'hff, 1'b1);
    // three-byte NAL whose header byte is really the next start code
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0);
    // IDR with first-mb set, one trailing zero before a four-byte start code
    send_beat(8'he5, 1'b0); send_beat(8'h80, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b0);
    // four-byte AUD after a picture: first-mb byte belongs to the next start code
    send_beat(8'h09, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0);
    // SEI, then a start code on the last byte of the stream: two results
    send_beat(8'h06, 1'b0);
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b1);
    // new stream: slice closed by end of stream with a trailing zero
    send_beat(8'h00, 1'b0); send_beat(8'h00, 1'b0); send_beat(8'h01, 1'b0);
    send_beat(8'h41, 1'b0); send_beat(8'h80, 1'b0); send_beat(8'h00, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle = 6;  recv_idle = 74; end
        1:       begin send_idle = 74; recv_idle = 6;  end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      target = sent + PHASE_BYTES;
      while (sent < target)
        emit_unit();
      if (phase == 0) begin
        // hold off until the output side has fully drained
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (failures == 0)
      $display("** h264_nal_access_unit_splitter_top: PASSED **");
    else
      $display("** h264_nal_access_unit_splitter_top: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** h264_nal_access_unit_splitter_top: FAILED **");
    $finish;
  end

endmodule
